// File: rtl/core/pvscq_pkg.sv
// Package for the PV string connect qualifier: widths, register map,
// configuration and lane status types. No dependencies.
`default_nettype none

package pvscq_pkg;

   // Number of solar input channels, one lane each (range 1 to 7).
   localparam int NUM_CHANNELS = 4;

   localparam int VOLT_W     = 16;
   localparam int THRESH_W   = 15;
   localparam int TICK_W     = 16;
   localparam int CHAN_CNT_W = 3;
   localparam int ON_CNT_W   = 3;

   // Sample width plus one bit, so unsigned thresholds compare as signed.
   localparam int CMP_W = VOLT_W + 1;

   localparam logic [TICK_W-1:0]   TICK_MAX = {TICK_W{1'b1}};
   localparam logic [ON_CNT_W-1:0] ON_MAX   = {ON_CNT_W{1'b1}};

   // Stream payload widths.
   localparam int REQ_DATA_W = NUM_CHANNELS * VOLT_W;
   localparam int REQ_USER_W = 2;
   localparam int RSP_BITS   = NUM_CHANNELS + ON_CNT_W + 2;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Register map: register i at byte address 4*i.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_START_VOLT       = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_TURN_OFF_VOLT    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_OFF_MARGIN       = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_CONNECT_TICKS    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_DISCONNECT_TICKS = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_HIGH_VOLT        = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_CHANNELS_IN_USE  = 3'd6;

   typedef struct packed {
      logic [THRESH_W-1:0]   start_volt;
      logic [THRESH_W-1:0]   turn_off_volt;
      logic [THRESH_W-1:0]   off_margin;
      logic [TICK_W-1:0]     connect_ticks;
      logic [TICK_W-1:0]     disconnect_ticks;
      logic [THRESH_W-1:0]   high_volt;
      logic [CHAN_CNT_W-1:0] channels_in_use;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      start_volt:       15'd2500,
      turn_off_volt:    15'd2000,
      off_margin:       15'd200,
      connect_ticks:    16'd200,
      disconnect_ticks: 16'd50,
      high_volt:        15'd11000,
      channels_in_use:  3'd4
   };

   // What one lane reports for the item being taken.
   typedef struct packed {
      logic connected;      // connected bit after this item
      logic connect_evt;    // channel connects on this item
      logic disconnect_evt; // channel disconnects on this item
      logic over_high;      // sample above the overvoltage level
   } lane_stat_type;

endpackage

`default_nettype wire

// File: rtl/core/pvscq_lane.sv
// One channel lane: connect / disconnect qualification with tick counters.
// Depends on pvscq_pkg.
`default_nettype none

module pvscq_lane (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   update,
   input  pvscq_pkg::cfg_type                     cfg,
   input  logic signed [pvscq_pkg::VOLT_W-1:0]    volt,
   output logic                                   connected,
   output pvscq_pkg::lane_stat_type               stat
);
   import pvscq_pkg::*;

   logic              connected_ff, connected_in;
   logic [TICK_W-1:0] conn_cnt_ff, conn_cnt_in;
   logic [TICK_W-1:0] disc_cnt_ff, disc_cnt_in;
   logic [TICK_W-1:0] conn_cnt_inc, disc_cnt_inc;

   logic signed [CMP_W-1:0] volt_x, start_x, turn_off_x, high_x, off_level;
   logic                    above_on, below_off;
   logic                    connect_evt, disconnect_evt;

   assign volt_x     = {volt[VOLT_W-1], volt};
   assign start_x    = $signed({2'b00, cfg.start_volt});
   assign turn_off_x = $signed({2'b00, cfg.turn_off_volt});
   assign high_x     = $signed({2'b00, cfg.high_volt});
   assign off_level  = turn_off_x - $signed({2'b00, cfg.off_margin});

   assign above_on  = (volt_x > start_x) && (volt_x > turn_off_x);
   assign below_off = volt_x < off_level;

   // Saturate at full scale.
   assign conn_cnt_inc = (conn_cnt_ff == TICK_MAX) ? conn_cnt_ff : conn_cnt_ff + 1'b1;
   assign disc_cnt_inc = (disc_cnt_ff == TICK_MAX) ? disc_cnt_ff : disc_cnt_ff + 1'b1;

   always_comb begin
      connected_in   = connected_ff;
      conn_cnt_in    = '0;
      disc_cnt_in    = '0;
      connect_evt    = 1'b0;
      disconnect_evt = 1'b0;
      if (!connected_ff) begin
         if (above_on) begin
            if (conn_cnt_inc > cfg.connect_ticks) begin
               connected_in = 1'b1;
               connect_evt  = 1'b1;
            end else begin
               conn_cnt_in = conn_cnt_inc;
            end
         end
      end else begin
         if (below_off) begin
            if (disc_cnt_inc > cfg.disconnect_ticks) begin
               connected_in   = 1'b0;
               disconnect_evt = 1'b1;
            end else begin
               disc_cnt_in = disc_cnt_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         connected_ff <= 1'b0;
         conn_cnt_ff  <= '0;
         disc_cnt_ff  <= '0;
      end else if (update) begin
         connected_ff <= connected_in;
         conn_cnt_ff  <= conn_cnt_in;
         disc_cnt_ff  <= disc_cnt_in;
      end
   end

   assign connected           = connected_ff;
   assign stat.connected      = connected_in;
   assign stat.connect_evt    = update & connect_evt;
   assign stat.disconnect_evt = update & disconnect_evt;
   assign stat.over_high      = volt_x > high_x;

endmodule

`default_nettype wire

// File: rtl/core/pvscq_merge.sv
// Merge stage: on-count chain in channel order, low and high flags.
// Depends on pvscq_pkg.
`default_nettype none

module pvscq_merge (
   input  logic                                                     clock,
   input  logic                                                     reset,
   input  logic                                                     update,
   input  logic                                                     svg_active,
   input  logic [pvscq_pkg::NUM_CHANNELS-1:0]                       lane_use,
   input  pvscq_pkg::lane_stat_type [pvscq_pkg::NUM_CHANNELS-1:0]   lane_stat,
   output logic [pvscq_pkg::ON_CNT_W-1:0]                           on_count,
   output logic                                                     volt_low_flag,
   output logic                                                     volt_high_flag
);
   import pvscq_pkg::*;

   logic [ON_CNT_W-1:0] on_count_ff, on_count_in;
   logic                low_ff, low_in;
   logic                high_ff, high_in;

   // Apply events lane by lane: increment saturates, decrement floors at 1.
   always_comb begin
      logic [ON_CNT_W-1:0] cnt_v;
      logic                any_on;
      logic                any_high;
      cnt_v    = on_count_ff;
      any_on   = 1'b0;
      any_high = 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (lane_use[i]) begin
            if (lane_stat[i].connect_evt) begin
               cnt_v = (cnt_v == ON_MAX) ? cnt_v : cnt_v + 1'b1;
            end else if (lane_stat[i].disconnect_evt) begin
               cnt_v = (cnt_v <= ON_CNT_W'(2)) ? ON_CNT_W'(1) : cnt_v - 1'b1;
            end
            any_on   = any_on | lane_stat[i].connected;
            any_high = any_high | lane_stat[i].over_high;
         end
      end
      on_count_in = cnt_v;
      low_in      = !any_on && !svg_active;
      high_in     = any_high;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_count_ff <= '0;
         low_ff      <= 1'b0;
         high_ff     <= 1'b0;
      end else if (update) begin
         on_count_ff <= on_count_in;
         low_ff      <= low_in;
         high_ff     <= high_in;
      end
   end

   assign on_count       = on_count_ff;
   assign volt_low_flag  = low_ff;
   assign volt_high_flag = high_ff;

endmodule

`default_nettype wire

// File: rtl/core/pv_string_connect_qualifier_core.sv
// Top level of the PV string connect qualifier: stream handshake, register
// file and lane array. Depends on pvscq_pkg, pvscq_lane and pvscq_merge.
`default_nettype none

// Channel   Direction  Handshake                Contents
// req_      in         tvalid/tready            one sample per channel + hold, svg flags
// rsp_      out        tvalid/tready            connected mask, on-count, low/high flags
// csr_      in/out     APB psel/penable/pready  seven configuration registers
//
// One item per cycle; results are registered. All channel lanes evaluate in
// parallel; the merge stage then walks the on-count through the lanes in
// channel order within the accepting cycle. The state registers double as
// the output register: an item is taken while the previous result is being
// taken in the same cycle. A stalled result stalls the input side; nothing
// is dropped. Reset clears all state and loads the register defaults.

module pv_string_connect_qualifier_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [pvscq_pkg::REQ_DATA_W-1:0]     req_tdata,  // volt_ch0 .. volt_ch3, 16 b each
   input  logic [pvscq_pkg::REQ_USER_W-1:0]     req_tuser,  // hold, svg_active
   // Result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [pvscq_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // connected_mask, on_count,
                                                            // volt_low_flag, volt_high_flag
   // Configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pvscq_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pvscq_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pvscq_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);
   import pvscq_pkg::*;

   cfg_type                cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic                   csr_write;

   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic                   accept;
   logic                   update;
   logic                   hold;
   logic                   svg_active;

   logic [NUM_CHANNELS-1:0]                connected_mask;
   logic [NUM_CHANNELS-1:0]                lane_use;
   lane_stat_type [NUM_CHANNELS-1:0]       lane_stat;
   logic [ON_CNT_W-1:0]                    on_count;
   logic                                   volt_low_flag;
   logic                                   volt_high_flag;

   // ---------------------------------------------------------------
   // Register file. Writes complete in the access phase.
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_idx)
            REG_START_VOLT:       cfg_in.start_volt       = csr_pwdata[THRESH_W-1:0];
            REG_TURN_OFF_VOLT:    cfg_in.turn_off_volt    = csr_pwdata[THRESH_W-1:0];
            REG_OFF_MARGIN:       cfg_in.off_margin       = csr_pwdata[THRESH_W-1:0];
            REG_CONNECT_TICKS:    cfg_in.connect_ticks    = csr_pwdata[TICK_W-1:0];
            REG_DISCONNECT_TICKS: cfg_in.disconnect_ticks = csr_pwdata[TICK_W-1:0];
            REG_HIGH_VOLT:        cfg_in.high_volt        = csr_pwdata[THRESH_W-1:0];
            REG_CHANNELS_IN_USE:  cfg_in.channels_in_use  = csr_pwdata[CHAN_CNT_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_START_VOLT:       csr_prdata = CSR_DATA_W'(cfg_ff.start_volt);
         REG_TURN_OFF_VOLT:    csr_prdata = CSR_DATA_W'(cfg_ff.turn_off_volt);
         REG_OFF_MARGIN:       csr_prdata = CSR_DATA_W'(cfg_ff.off_margin);
         REG_CONNECT_TICKS:    csr_prdata = CSR_DATA_W'(cfg_ff.connect_ticks);
         REG_DISCONNECT_TICKS: csr_prdata = CSR_DATA_W'(cfg_ff.disconnect_ticks);
         REG_HIGH_VOLT:        csr_prdata = CSR_DATA_W'(cfg_ff.high_volt);
         REG_CHANNELS_IN_USE:  csr_prdata = CSR_DATA_W'(cfg_ff.channels_in_use);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------
   // Handshake. Take an item whenever the result slot is free or is
   // being emptied this cycle; hold the result while the sink stalls.
   // ---------------------------------------------------------------
   assign req_tready    = !rsp_tvalid_ff || rsp_tready;
   assign accept        = req_tvalid && req_tready;
   assign rsp_tvalid_in = accept || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign hold       = req_tuser[0];
   assign svg_active = req_tuser[1];

   // Hold freezes every state bit; the result then repeats the stored state.
   assign update = accept && !hold;

   // ---------------------------------------------------------------
   // Lane array. Lanes past channels_in_use keep their state and are
   // left out of the flags, but still show in the mask.
   // ---------------------------------------------------------------
   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lane
      assign lane_use[i] = cfg_ff.channels_in_use > CHAN_CNT_W'(i);

      pvscq_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .update    (update && lane_use[i]),
         .cfg       (cfg_ff),
         .volt      ($signed(req_tdata[i*VOLT_W +: VOLT_W])),
         .connected (connected_mask[i]),
         .stat      (lane_stat[i])
      );
   end

   pvscq_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .update         (update),
      .svg_active     (svg_active),
      .lane_use       (lane_use),
      .lane_stat      (lane_stat),
      .on_count       (on_count),
      .volt_low_flag  (volt_low_flag),
      .volt_high_flag (volt_high_flag)
   );

   // The state registers hold exactly the result of the last item taken.
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_DATA_W'({volt_high_flag, volt_low_flag, on_count, connected_mask});

endmodule

`default_nettype wire
